>>> hw/rtl/mdsr_pkg.sv
// Package: shared types, constants and sequencer codes for the motor duty soft ramp.
`default_nettype none

package mdsr_pkg;

    // Ramp step limits and reset value
    localparam logic [7:0] STEP_MIN   = 8'd5;
    localparam logic [7:0] STEP_MAX   = 8'd128;
    localparam logic [7:0] STEP_RESET = 8'd10;

    // Walk stop levels
    localparam int CUR_W = 10;
    localparam logic signed [CUR_W-1:0] UP_STOP   = 10'sd254;
    localparam logic signed [CUR_W-1:0] DOWN_STOP = 10'sd1;

    // Direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    // Result kinds
    localparam logic KIND_DIR  = 1'b0;
    localparam logic KIND_DUTY = 1'b1;

    // Command transaction
    typedef struct packed {
        logic       motor;
        logic       opcode;
        logic [7:0] target_duty;
    } cmd_t;

    // Result transaction
    typedef struct packed {
        logic        kind;
        logic        channel;
        logic [1:0]  direction;
        logic [11:0] duty_out;
        logic        last;
    } result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIR,
        S_START,
        S_STEP,
        S_FINAL
    } state_t;

    // Status into the sequencer
    typedef struct packed {
        logic in_valid;
        logic dir_change;
        logic no_ramp;
        logic step_cont;
        logic slot_free;
    } seq_status_t;

    // Control out of the sequencer
    typedef struct packed {
        logic take_cmd;
        logic emit_dir;
        logic start_ramp;
        logic emit_step;
        logic emit_final;
    } seq_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/mdsr_step_unit.sv
// Shared add/subtract and stop-compare unit for one ramp step.
`default_nettype none

module mdsr_step_unit (
    input  wire logic signed [mdsr_pkg::CUR_W-1:0] cur,
    input  wire logic        [7:0]                 step,
    input  wire logic                              down,
    input  wire logic        [7:0]                 target,
    output logic signed      [mdsr_pkg::CUR_W-1:0] sum,
    output logic                                   cont
);

    logic signed [mdsr_pkg::CUR_W-1:0] step_s;
    logic signed [mdsr_pkg::CUR_W-1:0] target_s;

    assign step_s   = $signed({{(mdsr_pkg::CUR_W-8){1'b0}}, step});
    assign target_s = $signed({{(mdsr_pkg::CUR_W-8){1'b0}}, target});

    // One step toward the target, then check whether the walk goes on
    always_comb
    begin
        if (down)
        begin
            sum  = cur - step_s;
            cont = (target_s < sum) && (sum > mdsr_pkg::DOWN_STOP);
        end
        else
        begin
            sum  = cur + step_s;
            cont = (target_s > sum) && (sum < mdsr_pkg::UP_STOP);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mdsr_seq.sv
// Sequencer: steps one command through direction, ramp and final write.
`default_nettype none

module mdsr_seq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mdsr_pkg::seq_status_t status,
    output logic                       idle,
    output mdsr_pkg::seq_ctrl_t        ctrl
);

    mdsr_pkg::state_t state_reg;
    mdsr_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mdsr_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mdsr_pkg::S_IDLE:
                if (status.in_valid)
                    state_next = mdsr_pkg::S_DIR;
            mdsr_pkg::S_DIR:
                if (!status.dir_change || status.slot_free)
                    state_next = mdsr_pkg::S_START;
            mdsr_pkg::S_START:
                state_next = status.no_ramp ? mdsr_pkg::S_FINAL : mdsr_pkg::S_STEP;
            mdsr_pkg::S_STEP:
                if (!status.step_cont)
                    state_next = mdsr_pkg::S_FINAL;
            mdsr_pkg::S_FINAL:
                if (status.slot_free)
                    state_next = mdsr_pkg::S_IDLE;
            default:
                state_next = mdsr_pkg::S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        idle = 1'b0;
        ctrl = '0;
        unique case (state_reg)
            mdsr_pkg::S_IDLE:
            begin
                idle          = 1'b1;
                ctrl.take_cmd = status.in_valid;
            end
            mdsr_pkg::S_DIR:
                ctrl.emit_dir = status.dir_change && status.slot_free;
            mdsr_pkg::S_START:
                ctrl.start_ramp = 1'b1;
            mdsr_pkg::S_STEP:
                ctrl.emit_step = status.step_cont && status.slot_free;
            mdsr_pkg::S_FINAL:
                ctrl.emit_final = status.slot_free;
            default:
                idle = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/motor_duty_soft_ramp_core.sv
// Top level: two-motor soft-start duty ramp with direction handling.
// Usage:
//   in_valid/in_ready/in_data carry one command transaction (motor, opcode,
//   target_duty). out_valid/out_ready/out_data carry result transactions:
//   an optional direction-pins update, then one duty write per ramp level,
//   then the final duty write of the target with last set.
//   cfg_valid/cfg_ready/cfg_data write ramp_step; cfg_ready is always high.
//   Write it only while the block is idle.
// Timing:
//   A command is taken only in the idle state; in_ready stays low until its
//   final result is loaded into the output register. A command then passes
//   the direction and start states, the step state for each ramp level and
//   for the step that ends a walk, then the final state. One shared step
//   unit makes one ramp level per cycle while the output slot is free.
//   The first result is the direction update, else a step or the final write.
// Stall:
//   Results sit in one output register; while one waits with out_ready low,
//   the sequencer holds at its next result and nothing is lost or repeated.
// Reset:
//   rst_n clears both stored duties to 0, the last direction to none, and
//   ramp_step to 10.
`default_nettype none

module motor_duty_soft_ramp_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mdsr_pkg::cmd_t    in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mdsr_pkg::result_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data
);

    logic [7:0]                        ramp_step_reg;
    logic [7:0]                        left_duty_reg;
    logic [7:0]                        right_duty_reg;
    logic [1:0]                        last_dir_reg;
    logic                              motor_reg;
    logic [1:0]                        dir_reg;
    logic [7:0]                        target_reg;
    logic [7:0]                        step_reg;
    logic                              down_reg;
    logic signed [mdsr_pkg::CUR_W-1:0] cur_reg;
    logic                              out_valid_reg;
    mdsr_pkg::result_t                 out_data_reg;

    logic [7:0]                        step_eff;
    logic [7:0]                        duty_sel;
    logic signed [mdsr_pkg::CUR_W-1:0] sum;
    logic                              cont;
    logic                              idle;
    mdsr_pkg::seq_status_t             status;
    mdsr_pkg::seq_ctrl_t               ctrl;

    assign cfg_ready = 1'b1;
    assign in_ready  = idle;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Clamp the programmed step into its legal range
    always_comb
    begin
        if (ramp_step_reg < mdsr_pkg::STEP_MIN)
            step_eff = mdsr_pkg::STEP_MIN;
        else if (ramp_step_reg > mdsr_pkg::STEP_MAX)
            step_eff = mdsr_pkg::STEP_MAX;
        else
            step_eff = ramp_step_reg;
    end

    assign duty_sel = motor_reg ? right_duty_reg : left_duty_reg;

    // Sequencer status
    always_comb
    begin
        status.in_valid   = in_valid;
        status.dir_change = (last_dir_reg != dir_reg);
        status.no_ramp    = (target_reg == duty_sel);
        status.step_cont  = cont;
        status.slot_free  = !out_valid_reg || out_ready;
    end

    mdsr_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .idle   (idle),
        .ctrl   (ctrl)
    );

    mdsr_step_unit u_step (
        .cur    (cur_reg),
        .step   (step_reg),
        .down   (down_reg),
        .target (target_reg),
        .sum    (sum),
        .cont   (cont)
    );

    // Configuration, stored duties, last direction and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg  <= mdsr_pkg::STEP_RESET;
            left_duty_reg  <= '0;
            right_duty_reg <= '0;
            last_dir_reg   <= mdsr_pkg::DIR_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                ramp_step_reg <= cfg_data;

            // Direction change zeroes the commanded motor
            if (ctrl.emit_dir)
            begin
                last_dir_reg <= dir_reg;
                if (motor_reg)
                    right_duty_reg <= '0;
                else
                    left_duty_reg <= '0;
            end

            // Final write stores the target
            if (ctrl.emit_final)
            begin
                if (motor_reg)
                    right_duty_reg <= target_reg;
                else
                    left_duty_reg <= target_reg;
            end

            if (ctrl.emit_dir || ctrl.emit_step || ctrl.emit_final)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Command latch and ramp working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.take_cmd)
        begin
            motor_reg  <= in_data.motor;
            dir_reg    <= in_data.opcode ? mdsr_pkg::DIR_BWD : mdsr_pkg::DIR_FWD;
            target_reg <= in_data.target_duty;
            step_reg   <= step_eff;
        end
        if (ctrl.start_ramp)
        begin
            cur_reg  <= $signed({{(mdsr_pkg::CUR_W-8){1'b0}}, duty_sel});
            down_reg <= (target_reg < duty_sel);
        end
        else if (ctrl.emit_step)
        begin
            cur_reg <= sum;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (ctrl.emit_dir)
        begin
            out_data_reg.kind      <= mdsr_pkg::KIND_DIR;
            out_data_reg.channel   <= 1'b0;
            out_data_reg.direction <= dir_reg;
            out_data_reg.duty_out  <= '0;
            out_data_reg.last      <= 1'b0;
        end
        else if (ctrl.emit_step)
        begin
            out_data_reg.kind      <= mdsr_pkg::KIND_DUTY;
            out_data_reg.channel   <= motor_reg;
            out_data_reg.direction <= dir_reg;
            out_data_reg.duty_out  <= {sum[7:0], 4'b0000};
            out_data_reg.last      <= 1'b0;
        end
        else if (ctrl.emit_final)
        begin
            out_data_reg.kind      <= mdsr_pkg::KIND_DUTY;
            out_data_reg.channel   <= motor_reg;
            out_data_reg.direction <= dir_reg;
            out_data_reg.duty_out  <= {target_reg, 4'b0000};
            out_data_reg.last      <= 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the two-motor soft-start duty ramp core.
`default_nettype none

module tb_top;

    localparam int DUTY_SCALE  = 16;
    localparam int RAND_ITEMS  = 73;
    localparam int TIMEOUT_CYC = 2_000_000;

    // Scoreboard: predicted ramp state plus queue of expected result transactions
    class duty_ramp_scoreboard;
        logic [7:0]        step_reg;
        logic [7:0]        duty [2];
        logic [1:0]        last_dir;
        mdsr_pkg::result_t pending_results [$];
        int                errors;

        function void clear();
            step_reg = mdsr_pkg::STEP_RESET;
            duty[0]  = '0;
            duty[1]  = '0;
            last_dir = mdsr_pkg::DIR_NONE;
            errors   = 0;
            pending_results.delete();
        endfunction

        function void set_step(logic [7:0] value);
            step_reg = value;
        endfunction

        function void push_result(logic kind, logic chan, logic [1:0] dir, int level,
                                  logic fin);
            mdsr_pkg::result_t r;
            r.kind      = kind;
            r.channel   = chan;
            r.direction = dir;
            r.duty_out  = 12'(level * DUTY_SCALE);
            r.last      = fin;
            pending_results.push_back(r);
        endfunction

        // Expand one accepted command into its ramp of result transactions
        function void note_command(mdsr_pkg::cmd_t c);
            int         s;
            int         cur;
            int         tgt;
            logic [1:0] dir;
            s   = int'(step_reg);
            tgt = int'(c.target_duty);
            dir = c.opcode ? mdsr_pkg::DIR_BWD : mdsr_pkg::DIR_FWD;
            if (s < int'(mdsr_pkg::STEP_MIN))
                s = int'(mdsr_pkg::STEP_MIN);
            if (s > int'(mdsr_pkg::STEP_MAX))
                s = int'(mdsr_pkg::STEP_MAX);

            // direction change: pin update first, commanded motor restarts at zero
            if (last_dir != dir)
            begin
                push_result(mdsr_pkg::KIND_DIR, 1'b0, dir, 0, 1'b0);
                last_dir      = dir;
                duty[c.motor] = '0;
            end

            cur = int'(duty[c.motor]);
            if (tgt > cur)
            begin
                forever
                begin
                    cur += s;
                    if (!(tgt > cur) || cur >= int'(mdsr_pkg::UP_STOP))
                        break;
                    push_result(mdsr_pkg::KIND_DUTY, c.motor, dir, cur, 1'b0);
                end
            end
            else if (tgt < cur)
            begin
                forever
                begin
                    cur -= s;
                    if (!(tgt < cur) || cur <= int'(mdsr_pkg::DOWN_STOP))
                        break;
                    push_result(mdsr_pkg::KIND_DUTY, c.motor, dir, cur, 1'b0);
                end
            end

            // final write of the target always closes the command
            push_result(mdsr_pkg::KIND_DUTY, c.motor, dir, tgt, 1'b1);
            duty[c.motor] = c.target_duty;
        endfunction

        function void report(string field, int exp_val, int act_val);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
        endfunction

        function void check_result(mdsr_pkg::result_t r);
            mdsr_pkg::result_t e;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, r);
                return;
            end
            e = pending_results.pop_front();
            if (r.kind !== e.kind)
                report("kind", e.kind, r.kind);
            if (r.channel !== e.channel)
                report("channel", e.channel, r.channel);
            if (r.direction !== e.direction)
                report("direction", e.direction, r.direction);
            if (r.duty_out !== e.duty_out)
                report("duty_out", e.duty_out, r.duty_out);
            if (r.last !== e.last)
                report("last", e.last, r.last);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    mdsr_pkg::cmd_t    in_data;
    logic              out_valid;
    logic              out_ready;
    mdsr_pkg::result_t out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [7:0]        cfg_data;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    duty_ramp_scoreboard sb;

    motor_duty_soft_ramp_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: check accepted transactions, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Send one command; optional idle gap after acceptance
    task automatic drive_cmd(logic motor, logic opcode, logic [7:0] target);
        mdsr_pkg::cmd_t c;
        c.motor       = motor;
        c.opcode      = opcode;
        c.target_duty = target;
        in_valid <= 1'b1;
        in_data  <= c;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(c);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write; only called with the block idle
    task automatic write_step(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_step(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_cmd();
        logic       m;
        logic [7:0] t;
        m = 1'($urandom_range(1));
        case ($urandom_range(9))
            0:       t = 8'd0;
            1:       t = 8'd255;
            2:       t = sb.duty[m];
            3:       t = 8'($urandom_range(1, 6));
            4:       t = 8'($urandom_range(249, 254));
            default: t = 8'($urandom_range(255));
        endcase
        drive_cmd(m, 1'($urandom_range(1)), t);
    endtask

    initial
    begin
        int src_pcts [4];
        int sink_pcts [4];
        logic [7:0] step_val;
        src_pcts  = '{0, 67, 0, 19};
        sink_pcts = '{0, 0, 67, 19};

        sb = new;
        sb.clear();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stops, equal target, direction changes, step clamping
        drive_cmd(1'b0, 1'b0, 8'd4);
        drive_cmd(1'b0, 1'b0, 8'd255);   // upward walk stops at 254
        drive_cmd(1'b0, 1'b0, 8'd251);
        drive_cmd(1'b0, 1'b0, 8'd0);     // downward walk stops at 1
        drive_cmd(1'b0, 1'b0, 8'd0);     // target equals current duty
        drive_cmd(1'b1, 1'b1, 8'd200);
        drive_cmd(1'b0, 1'b1, 8'd127);
        drive_cmd(1'b0, 1'b1, 8'd128);
        drive_cmd(1'b1, 1'b0, 8'd254);
        drive_cmd(1'b1, 1'b0, 8'd1);
        drive_cmd(1'b0, 1'b1, 8'd0);     // direction change with zero target
        drain();
        write_step(8'd0);                // below minimum, used as 5
        drive_cmd(1'b1, 1'b1, 8'd255);
        drive_cmd(1'b1, 1'b1, 8'd0);
        drain();
        write_step(8'd255);              // above maximum, used as 128
        drive_cmd(1'b0, 1'b0, 8'd255);
        drive_cmd(1'b0, 1'b0, 8'd0);
        drain();
        write_step(8'd4);
        drive_cmd(1'b1, 1'b1, 8'd170);
        drain();
        write_step(8'd129);
        drive_cmd(1'b1, 1'b0, 8'd85);
        drain();
        write_step(mdsr_pkg::STEP_MIN);
        drive_cmd(1'b0, 1'b0, 8'd255);
        drain();
        write_step(mdsr_pkg::STEP_MAX);
        drive_cmd(1'b0, 1'b0, 8'd3);
        drain();

        // Random phases, each with its own step setting and idling pattern
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       step_val = 8'($urandom_range(0, 4));
                1:       step_val = 8'($urandom_range(129, 255));
                2:       step_val = 8'($urandom_range(5, 128));
                default: step_val = mdsr_pkg::STEP_RESET;
            endcase
            write_step(step_val);
            src_idle_pct   = src_pcts[p];
            sink_stall_pct = sink_pcts[p];
            for (int i = 0; i < RAND_ITEMS; i++)
                random_cmd();
            drain();
        end

        sink_stall_pct = 0;
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(12 * TIMEOUT_CYC);
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
